>>> design/wtse_pkg.sv
// ----------------------------------------------------------------------------
// wtse_pkg
// Shared types, codes and defaults of the windowed transfer session engine.
// ----------------------------------------------------------------------------
package wtse_pkg;

	localparam logic [15:0] UNIT_WINDOW_DEF = 16'd1024;
	localparam logic [15:0] MAX_WINDOW_DEF  = 16'd16384;
	localparam logic [3:0]  TLIM_RESET      = 4'd3;
	localparam logic [3:0]  SEG_CNT_LAST    = 4'd15;

	localparam logic [2:0] FN_REQUEST = 3'd0;
	localparam logic [2:0] FN_DATA    = 3'd1;
	localparam logic [2:0] FN_ACK     = 3'd2;
	localparam logic [2:0] FN_DONE    = 3'd3;
	localparam logic [2:0] FN_TIMEOUT = 3'd4;
	localparam logic [2:0] FN_ABORT   = 3'd5;

	localparam logic [1:0] KIND_SEG  = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_RPT  = 2'd3;

	localparam logic [1:0] PH_NONE      = 2'd0;
	localparam logic [1:0] PH_WAIT_ACK  = 2'd1;
	localparam logic [1:0] PH_WAIT_DATA = 2'd2;
	localparam logic [1:0] PH_WAIT_DONE = 2'd3;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_WINDOW   = 3'd1;
	localparam logic [2:0] ACT_ACK      = 3'd2;
	localparam logic [2:0] ACT_DONE_RPT = 3'd3;
	localparam logic [2:0] ACT_RPT      = 3'd4;

	localparam logic [1:0] SEL_SEG  = 2'd0;
	localparam logic [1:0] SEL_ACK  = 2'd1;
	localparam logic [1:0] SEL_DONE = 2'd2;
	localparam logic [1:0] SEL_RPT  = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic        ack_please;
		logic        seq_is_total;
		logic [31:0] seq;
		logic [31:0] length;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        out_ack_please;
		logic        out_seq_is_total;
		logic [31:0] out_seq;
		logic [15:0] out_length;
		logic [15:0] session_id;
		logic        success;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       capture;
		logic       eval;
		logic       setup;
		logic       load;
		logic [1:0] sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] act;
		logic       out_free;
		logic       seg_last;
	} dp_sts_t;

endpackage

>>> design/wtse_ctrl.sv
// ----------------------------------------------------------------------------
// wtse_ctrl
// Sequencer: takes a request, evaluates it, then issues its results one at a
// time into the output register.
// ----------------------------------------------------------------------------
module wtse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wtse_pkg::dp_sts_t   sts,
	output wtse_pkg::ctl_cmd_t  cmd
);
	import wtse_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_EVAL      = 3'd1;
	localparam logic [2:0] ST_SETUP     = 3'd2;
	localparam logic [2:0] ST_SEND      = 3'd3;
	localparam logic [2:0] ST_EMIT_ACK  = 3'd4;
	localparam logic [2:0] ST_EMIT_DONE = 3'd5;
	localparam logic [2:0] ST_EMIT_RPT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.sel     = SEL_SEG;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				unique case (sts.act)
					ACT_WINDOW:   state_nxt = ST_SETUP;
					ACT_ACK:      state_nxt = ST_EMIT_ACK;
					ACT_DONE_RPT: state_nxt = ST_EMIT_DONE;
					ACT_RPT:      state_nxt = ST_EMIT_RPT;
					default:      state_nxt = ST_IDLE;
				endcase
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = ST_SEND;
			end
			ST_SEND: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = SEL_SEG;
					if (sts.seg_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_EMIT_ACK: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					cmd.sel   = SEL_ACK;
					state_nxt = ST_IDLE;
				end
			end
			ST_EMIT_DONE: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					cmd.sel   = SEL_DONE;
					state_nxt = ST_EMIT_RPT;
				end
			end
			ST_EMIT_RPT: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					cmd.sel   = SEL_RPT;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> design/wtse_dp.sv
// ----------------------------------------------------------------------------
// wtse_dp
// Session state, event evaluation, window segment generator and output
// register.
// ----------------------------------------------------------------------------
module wtse_dp #(
	parameter logic [15:0] UNIT_WINDOW = wtse_pkg::UNIT_WINDOW_DEF,
	parameter logic [15:0] MAX_WINDOW  = wtse_pkg::MAX_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wtse_pkg::req_t      req_data,
	output logic                res_valid,
	input  logic                res_ready,
	output wtse_pkg::res_t      res_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  wtse_pkg::ctl_cmd_t  cmd,
	output wtse_pkg::dp_sts_t   sts
);
	import wtse_pkg::*;

	// session state
	logic        active_q;
	logic [1:0]  phase_q;
	logic [3:0]  tcnt_q;
	logic [31:0] total_q;
	logic [31:0] wstart_q;
	logic [15:0] wsize_q;
	logic [31:0] exp_q;
	logic [15:0] sid_q;
	logic        hbuf_q;
	logic [3:0]  tlim_q;

	// captured request and held result values
	req_t        ev_q;
	logic [31:0] hold_seq_q;
	logic        hold_succ_q;

	// segment generator
	logic [32:0] cur_q;
	logic [32:0] end_q;
	logic [15:0] seglen_q;
	logic [3:0]  cnt_q;

	res_t        res_q;
	res_t        res_nxt;
	logic        res_vld_q;

	// next values
	logic        n_active;
	logic [1:0]  n_phase;
	logic [3:0]  n_tcnt;
	logic [31:0] n_total;
	logic [31:0] n_wstart;
	logic [15:0] n_wsize;
	logic [31:0] n_exp;
	logic [15:0] n_sid;
	logic        n_hbuf;
	logic [2:0]  act;
	logic [31:0] h_seq;
	logic        h_succ;

	// data event terms
	logic        d_open;
	logic [1:0]  d_ph;
	logic [31:0] d_tot;
	logic [31:0] d_sq;
	logic [31:0] d_exp0;
	logic        d_hb0;
	logic [31:0] d_sum;

	// ack event terms
	logic [16:0] a_w2;
	logic [16:0] a_wc;
	logic        a_over;
	logic        a_gt;
	logic [31:0] a_diff;
	logic [15:0] a_wsize;

	// timeout terms
	logic [15:0] t_w;
	logic [15:0] t_w1;
	logic [15:0] t_w2;

	// segment terms
	logic [32:0] s_rem;
	logic [32:0] s_len;
	logic        s_ack;
	logic        s_last;
	logic        s_istot;

	assign d_open = !active_q;
	assign d_ph   = d_open ? PH_WAIT_DATA : phase_q;
	assign d_tot  = ev_q.seq_is_total ? ev_q.seq : (d_open ? 32'd0 : total_q);
	assign d_sq   = ev_q.seq_is_total ? 32'd0 : ev_q.seq;
	assign d_exp0 = d_open ? 32'd0 : exp_q;
	assign d_hb0  = d_open ? 1'b0 : hbuf_q;
	assign d_sum  = d_sq + ev_q.length;

	assign a_w2    = {wsize_q, 1'b0};
	assign a_wc    = (a_w2 > {1'b0, MAX_WINDOW}) ? {1'b0, MAX_WINDOW} : a_w2;
	assign a_over  = ({1'b0, ev_q.seq} + {16'd0, a_wc}) > {1'b0, total_q};
	assign a_gt    = ev_q.seq > total_q;
	assign a_diff  = total_q - ev_q.seq;
	assign a_wsize = a_over ? (a_gt ? 16'd0 : a_diff[15:0]) : a_wc[15:0];

	assign t_w  = {1'b0, wsize_q[15:1]};
	assign t_w1 = (t_w < UNIT_WINDOW) ? UNIT_WINDOW : t_w;
	assign t_w2 = ({16'd0, t_w1} > total_q) ? total_q[15:0] : t_w1;

	always_comb begin
		n_active = active_q;
		n_phase  = phase_q;
		n_tcnt   = tcnt_q;
		n_total  = total_q;
		n_wstart = wstart_q;
		n_wsize  = wsize_q;
		n_exp    = exp_q;
		n_sid    = sid_q;
		n_hbuf   = hbuf_q;
		act      = ACT_NONE;
		h_seq    = exp_q;
		h_succ   = 1'b0;
		unique case (ev_q.func)
			FN_REQUEST: begin
				n_active = 1'b1;
				n_phase  = PH_WAIT_ACK;
				n_tcnt   = 4'd0;
				n_total  = ev_q.length;
				n_wstart = 32'd0;
				n_wsize  = (ev_q.length < {16'd0, UNIT_WINDOW}) ? ev_q.length[15:0]
					: UNIT_WINDOW;
				n_exp    = 32'd0;
				n_sid    = sid_q + 16'd1;
				n_hbuf   = 1'b1;
				act      = ACT_WINDOW;
			end
			FN_DATA: begin
				if (d_open) begin
					n_active = 1'b1;
					n_phase  = PH_WAIT_DATA;
					n_tcnt   = 4'd0;
					n_wstart = 32'd0;
					n_wsize  = 16'd0;
					n_exp    = 32'd0;
					n_hbuf   = 1'b0;
					n_sid    = sid_q + 16'd1;
				end
				n_total = d_tot;
				if (d_hb0 || d_tot != 32'd0) begin
					n_hbuf = 1'b1;
					if (d_ph == PH_WAIT_DATA) begin
						n_tcnt = 4'd0;
						if (d_sq == d_exp0) begin
							n_exp = d_sum;
							if (ev_q.ack_please) begin
								act   = ACT_ACK;
								h_seq = d_sum;
								if (d_sum == d_tot) begin
									n_phase = PH_WAIT_DONE;
								end
							end
						end else if (d_sq > d_exp0) begin
							act   = ACT_ACK;
							h_seq = d_exp0;
							if (d_exp0 == d_tot) begin
								n_phase = PH_WAIT_DONE;
							end
						end
					end
				end
			end
			FN_ACK: begin
				if (active_q && phase_q == PH_WAIT_ACK) begin
					n_tcnt   = 4'd0;
					n_wstart = ev_q.seq;
					n_wsize  = a_wsize;
					if (ev_q.seq == total_q) begin
						act      = ACT_DONE_RPT;
						h_seq    = exp_q;
						h_succ   = 1'b1;
						n_active = 1'b0;
						n_phase  = PH_NONE;
						n_total  = 32'd0;
						n_wstart = 32'd0;
						n_wsize  = 16'd0;
						n_exp    = 32'd0;
						n_hbuf   = 1'b0;
					end else begin
						act = ACT_WINDOW;
					end
				end
			end
			FN_DONE: begin
				if (active_q && phase_q == PH_WAIT_DONE) begin
					act      = ACT_RPT;
					h_succ   = 1'b1;
					n_active = 1'b0;
					n_phase  = PH_NONE;
					n_tcnt   = 4'd0;
					n_total  = 32'd0;
					n_wstart = 32'd0;
					n_wsize  = 16'd0;
					n_exp    = 32'd0;
					n_hbuf   = 1'b0;
				end
			end
			FN_TIMEOUT: begin
				if (active_q) begin
					if (tcnt_q >= tlim_q) begin
						act      = ACT_RPT;
						h_succ   = (phase_q == PH_WAIT_DONE);
						n_active = 1'b0;
						n_phase  = PH_NONE;
						n_tcnt   = 4'd0;
						n_total  = 32'd0;
						n_wstart = 32'd0;
						n_wsize  = 16'd0;
						n_exp    = 32'd0;
						n_hbuf   = 1'b0;
					end else begin
						n_tcnt = tcnt_q + 4'd1;
						if (phase_q == PH_WAIT_ACK) begin
							n_wsize = t_w2;
							act     = ACT_WINDOW;
						end else if (phase_q == PH_WAIT_DATA || phase_q == PH_WAIT_DONE) begin
							act   = ACT_ACK;
							h_seq = exp_q;
							if (exp_q == total_q) begin
								n_phase = PH_WAIT_DONE;
							end
						end
					end
				end
			end
			FN_ABORT: begin
				if (active_q) begin
					n_active = 1'b0;
					n_phase  = PH_NONE;
					n_tcnt   = 4'd0;
					n_total  = 32'd0;
					n_wstart = 32'd0;
					n_wsize  = 16'd0;
					n_exp    = 32'd0;
					n_hbuf   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// segment generator
	assign s_rem   = end_q - cur_q;
	assign s_len   = ({17'd0, seglen_q} > s_rem) ? s_rem : {17'd0, seglen_q};
	assign s_ack   = (s_len == s_rem);
	assign s_last  = s_ack || (cnt_q == SEG_CNT_LAST);
	assign s_istot = (cur_q == 33'd0);

	assign sts.act      = act;
	assign sts.out_free = !res_vld_q || res_ready;
	assign sts.seg_last = s_last;

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// next result header
	always_comb begin
		res_nxt            = '0;
		res_nxt.session_id = sid_q;
		unique case (cmd.sel)
			SEL_SEG: begin
				res_nxt.kind             = KIND_SEG;
				res_nxt.out_ack_please   = s_ack;
				res_nxt.out_seq_is_total = s_istot;
				res_nxt.out_seq          = s_istot ? total_q : cur_q[31:0];
				res_nxt.out_length       = s_len[15:0];
				res_nxt.last             = s_last;
			end
			SEL_ACK: begin
				res_nxt.kind    = KIND_ACK;
				res_nxt.out_seq = hold_seq_q;
				res_nxt.last    = 1'b1;
			end
			SEL_DONE: begin
				res_nxt.kind    = KIND_DONE;
				res_nxt.out_seq = hold_seq_q;
			end
			SEL_RPT: begin
				res_nxt.kind    = KIND_RPT;
				res_nxt.success = hold_succ_q;
				res_nxt.last    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			phase_q   <= PH_NONE;
			tcnt_q    <= 4'd0;
			total_q   <= 32'd0;
			wstart_q  <= 32'd0;
			wsize_q   <= 16'd0;
			exp_q     <= 32'd0;
			sid_q     <= 16'd0;
			hbuf_q    <= 1'b0;
			tlim_q    <= TLIM_RESET;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tlim_q <= cfg_wdata;
			end
			if (cmd.eval) begin
				active_q <= n_active;
				phase_q  <= n_phase;
				tcnt_q   <= n_tcnt;
				total_q  <= n_total;
				wstart_q <= n_wstart;
				wsize_q  <= n_wsize;
				exp_q    <= n_exp;
				sid_q    <= n_sid;
				hbuf_q   <= n_hbuf;
			end
			if (cmd.load) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ev_q <= req_data;
		end
		if (cmd.eval) begin
			hold_seq_q  <= h_seq;
			hold_succ_q <= h_succ;
		end
		if (cmd.setup) begin
			cur_q    <= {1'b0, wstart_q};
			end_q    <= {1'b0, wstart_q} + {17'd0, wsize_q};
			seglen_q <= (wsize_q < UNIT_WINDOW) ? wsize_q : UNIT_WINDOW;
			cnt_q    <= 4'd0;
		end else if (cmd.load && cmd.sel == SEL_SEG) begin
			cur_q <= cur_q + s_len;
			cnt_q <= cnt_q + 4'd1;
		end
		if (cmd.load) begin
			res_q <= res_nxt;
		end
	end

endmodule

>>> design/windowed_transfer_session_engine.sv
// ----------------------------------------------------------------------------
// windowed_transfer_session_engine
// Single-slot reliable transfer session engine: request, data, ack, done,
// timeout and abort events in; data segments, acks, done and reports out.
// ----------------------------------------------------------------------------
// order: a taken request is captured and evaluated; for a window send the segment
//   generator is then set up; results are loaded one at a time into the output register
// throughput: one result per cycle while the output register is free; a new
//   request is taken only after the sequencer has issued every result of the
//   last one (up to 16 segments for a window) and is back in idle
// reset: arst_n clears the session, the id counter and sets timeout_limit to 3
module windowed_transfer_session_engine #(
	parameter logic [15:0] UNIT_WINDOW = wtse_pkg::UNIT_WINDOW_DEF,
	parameter logic [15:0] MAX_WINDOW  = wtse_pkg::MAX_WINDOW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  wtse_pkg::req_t  req_data,
	output logic            res_valid,
	input  logic            res_ready,
	output wtse_pkg::res_t  res_data,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_wdata
);
	import wtse_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	wtse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wtse_dp #(
		.UNIT_WINDOW (UNIT_WINDOW),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.out_free)
		else $error("pending result overwritten");

	a_done_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_DONE |-> !res_data.last)
		else $error("done result marked last");

	a_rpt_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.sel == SEL_RPT |=> res_valid && res_data.kind == KIND_RPT
		&& res_data.last)
		else $error("report not issued as final result");
`endif

endmodule
